// File: sv/spi_motor_turret_controller_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor and turret controller
// Shared forms for the concurrent checks on the controller's ports.
// ----------------------------------------------------------------------------
`ifndef SPI_MOTOR_TURRET_CONTROLLER_TOP_ASSERT_SVH
`define SPI_MOTOR_TURRET_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SMTC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SMTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Delayed form of the next-cycle implication, disabled while reset is high.
`define SMTC_ASSERT_LATER(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error("two-cycle check failed");

`endif

// File: sv/smtc_pkg.sv
// ----------------------------------------------------------------------------
// smtc_pkg
// Types, codes and reset values shared by the motor and turret controller.
// ----------------------------------------------------------------------------
package smtc_pkg;

   localparam int MODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int SIDX_W  = 3;
   localparam int DUTY_W  = 8;
   localparam int DATA_W  = 5;
   localparam int CODE_W  = 3;
   localparam int CSR_W   = 16;
   localparam int CSRI_W  = 3;
   localparam int LEG_COUNT = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_COMMAND = 2'd0,
      MODE_TICK    = 2'd1,
      MODE_SAMPLE  = 2'd2
   } mode_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_SENSOR    = 3'd0,
      CODE_RESET     = 3'd1,
      CODE_RIGHT     = 3'd2,
      CODE_LEFT      = 3'd3,
      CODE_M1_FWD    = 3'd4,
      CODE_M1_REV    = 3'd5,
      CODE_M2_FWD    = 3'd6,
      CODE_M2_REV    = 3'd7
   } code_type;

   typedef enum logic [CSRI_W-1:0] {
      CSR_MOTOR_GAIN   = 3'd0,
      CSR_MOTOR_OFFSET = 3'd1,
      CSR_PWM_PERIOD   = 3'd2,
      CSR_DUTY_STEP    = 3'd3,
      CSR_DUTY_OFFSET  = 3'd4
   } csr_index_type;

   localparam logic [DATA_W-1:0] DATA_LED_ON     = 5'd10;
   localparam logic [DATA_W-1:0] DATA_LED_OFF    = 5'd11;
   localparam logic [DATA_W-1:0] DATA_LED_TOGGLE = 5'd12;
   localparam logic [DATA_W-1:0] DATA_ALL_RESET  = 5'd31;

   localparam logic [7:0]  RESET_MOTOR_GAIN   = 8'd6;
   localparam logic [7:0]  RESET_MOTOR_OFFSET = 8'd69;
   localparam logic [15:0] RESET_PWM_PERIOD   = 16'd1333;
   localparam logic [15:0] RESET_DUTY_STEP    = 16'd26;
   localparam logic [15:0] RESET_DUTY_OFFSET  = 16'd527;

   // One processed item as seen by the motor and turret units.
   typedef struct packed {
      logic                command;
      logic                tick;
      logic [CODE_W-1:0]   code;
      logic [DATA_W-1:0]   data;
   } ctl_type;

endpackage

// File: sv/smtc_if.sv
// ----------------------------------------------------------------------------
// smtc_req_if / smtc_rsp_if
// Valid/ready channels for the controller's input items and result items.
// ----------------------------------------------------------------------------
interface smtc_req_if
   import smtc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] command_byte;
   logic [SIDX_W-1:0] sensor_index;
   logic [BYTE_W-1:0] sensor_value;

   modport source (output valid, mode, command_byte, sensor_index, sensor_value,
                   input ready);
   modport sink   (input valid, mode, command_byte, sensor_index, sensor_value,
                   output ready);
endinterface

interface smtc_rsp_if
   import smtc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] motor1_forward_duty;
   logic [DUTY_W-1:0] motor1_reverse_duty;
   logic [DUTY_W-1:0] motor2_forward_duty;
   logic [DUTY_W-1:0] motor2_reverse_duty;
   logic              turret_left_drive;
   logic              turret_right_drive;
   logic              led_level;
   logic [BYTE_W-1:0] reply_byte;
   logic              reply_loaded;

   modport source (output valid, motor1_forward_duty, motor1_reverse_duty,
                   motor2_forward_duty, motor2_reverse_duty, turret_left_drive,
                   turret_right_drive, led_level, reply_byte, reply_loaded,
                   input ready);
   modport sink   (input valid, motor1_forward_duty, motor1_reverse_duty,
                   motor2_forward_duty, motor2_reverse_duty, turret_left_drive,
                   turret_right_drive, led_level, reply_byte, reply_loaded,
                   output ready);
endinterface

// File: sv/smtc_motor.sv
// ----------------------------------------------------------------------------
// smtc_motor
// Holds the four motor leg duties and applies speed and reset commands.
// ----------------------------------------------------------------------------
module smtc_motor
   import smtc_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  ctl_type                          ctl,
   input  logic [7:0]                       motor_gain,
   input  logic [7:0]                       motor_offset,
   output logic [LEG_COUNT-1:0][DUTY_W-1:0] duty_next
);

   logic [LEG_COUNT-1:0][DUTY_W-1:0] duty_ff;
   logic [LEG_COUNT-1:0][DUTY_W-1:0] duty_in;
   logic [12:0]                      product;
   logic [13:0]                      level;
   logic [DUTY_W-1:0]                value;
   logic [1:0]                       leg;

   always_comb begin
      product = 13'(ctl.data) * 13'(motor_gain);
      level   = 14'(product) + 14'(motor_offset);
      if (ctl.data == '0) begin
         value = '0;
      end else if (level > 14'd255) begin
         value = 8'hFF;
      end else begin
         value = level[7:0];
      end
      leg = ctl.code[1:0];

      duty_in = duty_ff;
      if (ctl.command) begin
         if (ctl.code[2]) begin
            // The opposite leg of the same motor is released first.
            duty_in[leg ^ 2'd1] = '0;
            duty_in[leg]        = value;
         end else if (ctl.code == CODE_RESET && ctl.data == DATA_ALL_RESET) begin
            duty_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
      end else begin
         duty_ff <= duty_in;
      end
   end

   assign duty_next = duty_in;

endmodule

// File: sv/smtc_turret.sv
// ----------------------------------------------------------------------------
// smtc_turret
// Turret direction and soft PWM: duty commands, tick countdown, drive pins.
// ----------------------------------------------------------------------------
module smtc_turret
   import smtc_pkg::*;
#(
   parameter int TIMER_BITS = 16,
   parameter int MAX_DUTY   = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   input  logic [15:0] pwm_period,
   input  logic [15:0] duty_step,
   input  logic [15:0] duty_offset,
   output logic        left_next,
   output logic        right_next
);

   localparam int                SUM_W    = TIMER_BITS + 22;
   localparam logic [DATA_W-1:0] MAX_CODE = DATA_W'(MAX_DUTY);

   logic                  left_ff, left_in;
   logic                  right_ff, right_in;
   logic                  turn_left_ff, turn_left_in;
   logic                  high_phase_ff, high_phase_in;
   logic                  running_ff, running_in;
   logic [TIMER_BITS-1:0] high_len_ff, high_len_in;
   logic [TIMER_BITS-1:0] low_len_ff, low_len_in;
   logic [TIMER_BITS-1:0] count_ff, count_in;
   logic [20:0]           product;
   logic [SUM_W-1:0]      high_wide;
   logic [SUM_W-1:0]      low_wide;
   logic [TIMER_BITS-1:0] high_calc;
   logic [TIMER_BITS-1:0] low_calc;
   logic [TIMER_BITS-1:0] count_dec;
   logic                  dir_left;

   always_comb begin
      product   = 21'(duty_step) * 21'(ctl.data);
      high_wide = SUM_W'(duty_offset) + SUM_W'(product);
      high_calc = high_wide[TIMER_BITS-1:0];
      low_wide  = SUM_W'(pwm_period) - SUM_W'(high_calc);
      low_calc  = low_wide[TIMER_BITS-1:0];
      count_dec = count_ff - TIMER_BITS'(1);
      dir_left  = (ctl.code == CODE_LEFT);

      left_in       = left_ff;
      right_in      = right_ff;
      turn_left_in  = turn_left_ff;
      high_phase_in = high_phase_ff;
      running_in    = running_ff;
      high_len_in   = high_len_ff;
      low_len_in    = low_len_ff;
      count_in      = count_ff;

      if (ctl.command) begin
         unique case (ctl.code)
            CODE_RESET: begin
               if (ctl.data == DATA_ALL_RESET) begin
                  left_in  = 1'b0;
                  right_in = 1'b0;
               end
            end
            CODE_RIGHT, CODE_LEFT: begin
               turn_left_in = dir_left;
               if (ctl.data == '0) begin
                  running_in = 1'b0;
                  left_in    = 1'b0;
                  right_in   = 1'b0;
               end else if (ctl.data >= MAX_CODE) begin
                  running_in = 1'b0;
                  left_in    = dir_left;
                  right_in   = !dir_left;
               end else begin
                  high_len_in = high_calc;
                  low_len_in  = low_calc;
                  // A stopped PWM starts in its low phase.
                  if (!running_ff) begin
                     high_phase_in = 1'b0;
                     count_in      = low_calc;
                     running_in    = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (ctl.tick && running_ff) begin
         count_in = count_dec;
         if (count_dec == '0) begin
            if (high_phase_ff) begin
               left_in       = 1'b0;
               right_in      = 1'b0;
               count_in      = low_len_ff;
               high_phase_in = 1'b0;
            end else begin
               left_in       = turn_left_ff;
               right_in      = !turn_left_ff;
               count_in      = high_len_ff;
               high_phase_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= 1'b0;
         right_ff      <= 1'b0;
         turn_left_ff  <= 1'b1;
         high_phase_ff <= 1'b0;
         running_ff    <= 1'b0;
         high_len_ff   <= '0;
         low_len_ff    <= '0;
         count_ff      <= '0;
      end else begin
         left_ff       <= left_in;
         right_ff      <= right_in;
         turn_left_ff  <= turn_left_in;
         high_phase_ff <= high_phase_in;
         running_ff    <= running_in;
         high_len_ff   <= high_len_in;
         low_len_ff    <= low_len_in;
         count_ff      <= count_in;
      end
   end

   assign left_next  = left_in;
   assign right_next = right_in;

endmodule

// File: sv/spi_motor_turret_controller_top.sv
// ----------------------------------------------------------------------------
// spi_motor_turret_controller_top
// Command decoder for two DC motors, a soft-PWM turret, an LED and sensors.
// ----------------------------------------------------------------------------
// Every accepted item produces exactly one result item, and the block sustains
// one item per clock while results are taken. An item is first held in the
// input register; as it leaves, the decode and state update logic (motor duty
// multiply-add, turret length add and subtract, sensor and LED handling)
// computes the state after the item, which is written to the state registers
// and captured in the result register at the same edge, and shown from there.
// While a result waits, the input register can still take one more item, and
// ready falls only when both registers are full and the result is not taken.
// Configuration writes take effect at the edge of the write and must be
// made while no item is in flight. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module spi_motor_turret_controller_top
   import smtc_pkg::*;
#(
   parameter int SENSOR_COUNT = 5,
   parameter int TIMER_BITS   = 16,
   parameter int MAX_DUTY     = 31
) (
   input  logic              clock,
   input  logic              reset,
   smtc_req_if.sink          req_chan,
   smtc_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [CSRI_W-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_data
);

   localparam int SIDX_BITS = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   // Configuration registers.
   logic [7:0]  motor_gain_ff;
   logic [7:0]  motor_offset_ff;
   logic [15:0] pwm_period_ff;
   logic [15:0] duty_step_ff;
   logic [15:0] duty_offset_ff;

   // Input register.
   logic              in_valid_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [BYTE_W-1:0] command_ff;
   logic [SIDX_W-1:0] sensor_index_ff;
   logic [BYTE_W-1:0] sensor_value_ff;

   // Block state held here; motor and turret state live in their units.
   logic [BYTE_W-1:0] sensor_ff [SENSOR_COUNT];
   logic              led_ff, led_in;
   logic [BYTE_W-1:0] reply_ff, reply_in;
   logic              loaded_in;
   logic              sample_we;

   // Result register.
   logic                             out_valid_ff;
   logic [LEG_COUNT-1:0][DUTY_W-1:0] out_duty_ff;
   logic                             out_left_ff;
   logic                             out_right_ff;
   logic                             out_led_ff;
   logic [BYTE_W-1:0]                out_reply_ff;
   logic                             out_loaded_ff;

   logic                             advance;
   ctl_type                          ctl;
   logic [LEG_COUNT-1:0][DUTY_W-1:0] duty_next;
   logic                             left_next;
   logic                             right_next;
   logic [DATA_W-1:0]                read_sel;

   // The stored item moves on whenever the result register is free or drained.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      ctl.command = advance && (mode_ff == MODE_COMMAND);
      ctl.tick    = advance && (mode_ff == MODE_TICK);
      ctl.code    = command_ff[7:5];
      ctl.data    = command_ff[4:0];
   end

   smtc_motor u_motor (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .motor_gain   (motor_gain_ff),
      .motor_offset (motor_offset_ff),
      .duty_next    (duty_next)
   );

   smtc_turret #(
      .TIMER_BITS (TIMER_BITS),
      .MAX_DUTY   (MAX_DUTY)
   ) u_turret (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .pwm_period  (pwm_period_ff),
      .duty_step   (duty_step_ff),
      .duty_offset (duty_offset_ff),
      .left_next   (left_next),
      .right_next  (right_next)
   );

   // Sensor readback, LED commands and the all-reset command's LED effect.
   always_comb begin
      led_in    = led_ff;
      reply_in  = reply_ff;
      loaded_in = 1'b0;
      read_sel  = ctl.data - DATA_W'(1);
      if (ctl.command) begin
         if (ctl.code == CODE_SENSOR) begin
            if (ctl.data != '0 && ctl.data <= DATA_W'(SENSOR_COUNT)) begin
               reply_in  = sensor_ff[read_sel[SIDX_BITS-1:0]];
               loaded_in = 1'b1;
            end else if (ctl.data == DATA_LED_ON) begin
               led_in = 1'b0;
            end else if (ctl.data == DATA_LED_OFF) begin
               led_in = 1'b1;
            end else if (ctl.data == DATA_LED_TOGGLE) begin
               led_in = !led_ff;
            end
         end else if (ctl.code == CODE_RESET && ctl.data == DATA_ALL_RESET) begin
            led_in = 1'b1;
         end
      end
      // Samples for a sensor that does not exist are dropped.
      sample_we = advance && (mode_ff == MODE_SAMPLE)
                  && ({1'b0, sensor_index_ff} < (SIDX_W + 1)'(SENSOR_COUNT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_gain_ff   <= RESET_MOTOR_GAIN;
         motor_offset_ff <= RESET_MOTOR_OFFSET;
         pwm_period_ff   <= RESET_PWM_PERIOD;
         duty_step_ff    <= RESET_DUTY_STEP;
         duty_offset_ff  <= RESET_DUTY_OFFSET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MOTOR_GAIN:   motor_gain_ff   <= csr_data[7:0];
            CSR_MOTOR_OFFSET: motor_offset_ff <= csr_data[7:0];
            CSR_PWM_PERIOD:   pwm_period_ff   <= csr_data;
            CSR_DUTY_STEP:    duty_step_ff    <= csr_data;
            CSR_DUTY_OFFSET:  duty_offset_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         mode_ff         <= req_chan.mode;
         command_ff      <= req_chan.command_byte;
         sensor_index_ff <= req_chan.sensor_index;
         sensor_value_ff <= req_chan.sensor_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            sensor_ff[i] <= '0;
         end
         led_ff   <= 1'b1;
         reply_ff <= '0;
      end else begin
         if (sample_we) begin
            sensor_ff[sensor_index_ff[SIDX_BITS-1:0]] <= sensor_value_ff;
         end
         led_ff   <= led_in;
         reply_ff <= reply_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_duty_ff   <= duty_next;
         out_left_ff   <= left_next;
         out_right_ff  <= right_next;
         out_led_ff    <= led_in;
         out_reply_ff  <= reply_in;
         out_loaded_ff <= loaded_in;
      end
   end

   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.motor1_forward_duty = out_duty_ff[0];
   assign rsp_chan.motor1_reverse_duty = out_duty_ff[1];
   assign rsp_chan.motor2_forward_duty = out_duty_ff[2];
   assign rsp_chan.motor2_reverse_duty = out_duty_ff[3];
   assign rsp_chan.turret_left_drive   = out_left_ff;
   assign rsp_chan.turret_right_drive  = out_right_ff;
   assign rsp_chan.led_level           = out_led_ff;
   assign rsp_chan.reply_byte          = out_reply_ff;
   assign rsp_chan.reply_loaded        = out_loaded_ff;

endmodule

// File: sv/smtc_checker.sv
// ----------------------------------------------------------------------------
// smtc_checker
// Port-level checks on the controller, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "spi_motor_turret_controller_top_assert.svh"

module smtc_checker
   import smtc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DUTY_W-1:0] m1_fwd,
   input logic [DUTY_W-1:0] m1_rev,
   input logic [DUTY_W-1:0] m2_fwd,
   input logic [DUTY_W-1:0] m2_rev,
   input logic              left_drive,
   input logic              right_drive,
   input logic              led_level,
   input logic [BYTE_W-1:0] reply_byte,
   input logic              reply_loaded
);

   logic [4*DUTY_W+BYTE_W+3:0] payload;

   assign payload = {m1_fwd, m1_rev, m2_fwd, m2_rev, left_drive, right_drive,
                     led_level, reply_byte, reply_loaded};

   // A held result keeps its value until it is taken.
   `SMTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(payload))

   // The turret is never driven in both directions at once.
   `SMTC_ASSERT_IMPLY(a_turret_excl, clock, reset, rsp_valid, !(left_drive && right_drive))

   // Setting a motor leg releases the other, so both legs never run together.
   `SMTC_ASSERT_IMPLY(a_motor_excl, clock, reset, rsp_valid, (m1_fwd == '0 || m1_rev == '0) && (m2_fwd == '0 || m2_rev == '0))

   // An item taken while no result is pending has its result shown after the input and result registers.
   `SMTC_ASSERT_LATER(a_latency, clock, reset, req_valid && req_ready && !rsp_valid, rsp_valid)

endmodule

bind spi_motor_turret_controller_top smtc_checker u_smtc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .m1_fwd       (rsp_chan.motor1_forward_duty),
   .m1_rev       (rsp_chan.motor1_reverse_duty),
   .m2_fwd       (rsp_chan.motor2_forward_duty),
   .m2_rev       (rsp_chan.motor2_reverse_duty),
   .left_drive   (rsp_chan.turret_left_drive),
   .right_drive  (rsp_chan.turret_right_drive),
   .led_level    (rsp_chan.led_level),
   .reply_byte   (rsp_chan.reply_byte),
   .reply_loaded (rsp_chan.reply_loaded)
);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the motor and turret command controller. A
// predictor inside the bench tracks the motor duties, turret soft PWM, LED
// and sensor store. It computes the output state expected after every
// accepted item. Each result item is then compared field by field, in
// order. The sender and the receiver both idle at random between items.
// ----------------------------------------------------------------------------
module tb;
   import smtc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Build-time sizes of the controller under test, matching its defaults.
   localparam int SENSOR_COUNT = 5;
   localparam int MAX_DUTY     = 31;

   // Mode code that the controller must ignore.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Expected output state after one item, in the order of the result fields.
   typedef struct packed {
      logic [DUTY_W-1:0] m1_fwd;
      logic [DUTY_W-1:0] m1_rev;
      logic [DUTY_W-1:0] m2_fwd;
      logic [DUTY_W-1:0] m2_rev;
      logic              left_drive;
      logic              right_drive;
      logic              led;
      logic [BYTE_W-1:0] reply;
      logic              loaded;
   } outputs_type;

   logic clock;
   logic reset;
   logic              csr_we;
   logic [CSRI_W-1:0] csr_index;
   logic [CSR_W-1:0]  csr_data;

   smtc_req_if req_chan ();
   smtc_rsp_if rsp_chan ();

   spi_motor_turret_controller_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // The bench's own copy of the configuration registers.
   logic [7:0]  gain_cfg;
   logic [7:0]  offset_cfg;
   logic [15:0] period_cfg;
   logic [15:0] step_cfg;
   logic [15:0] base_cfg;

   // The bench's own copy of the controller state.
   logic [7:0]  sensor_mem [SENSOR_COUNT];
   logic [7:0]  leg_duty [LEG_COUNT];
   logic        drive_left;
   logic        drive_right;
   logic        heading_left;
   logic        in_high;
   logic        pwm_on;
   logic [15:0] high_ticks;
   logic [15:0] low_ticks;
   logic [15:0] ticks_left;
   logic        led_q;
   logic [7:0]  reply_q;

   // Output states still owed by the controller, oldest first.
   outputs_type expected_outputs [$];

   int errors = 0;
   int items_sent = 0;
   int rsp_wait = 0;
   // When set, neither side idles; this gives back-to-back stretches.
   bit no_idle = 0;

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Drive the pin of the current heading and hold the other one low.
   task automatic drive_heading();
      drive_left  = heading_left;
      drive_right = !heading_left;
   endtask

   // A turret duty of zero stops the PWM with both pins low. The full duty
   // stops it with the heading pin held high. Any other duty reloads both
   // phase lengths. A stopped PWM restarts at the top of its low phase, while
   // a running one keeps its phase and countdown.
   task automatic turret_duty(input logic [DATA_W-1:0] d);
      if (d == '0) begin
         pwm_on      = 1'b0;
         drive_left  = 1'b0;
         drive_right = 1'b0;
      end else if (d >= DATA_W'(MAX_DUTY)) begin
         pwm_on = 1'b0;
         drive_heading();
      end else begin
         high_ticks = base_cfg + step_cfg * 16'(d);
         low_ticks  = period_cfg - high_ticks;
         if (!pwm_on) begin
            in_high    = 1'b0;
            ticks_left = low_ticks;
            pwm_on     = 1'b1;
         end
      end
   endtask

   // A length of zero wraps through the full 16-bit count.
   task automatic pwm_tick();
      if (pwm_on) begin
         ticks_left = ticks_left - 16'd1;
         if (ticks_left == '0) begin
            if (in_high) begin
               drive_left  = 1'b0;
               drive_right = 1'b0;
               ticks_left  = low_ticks;
               in_high     = 1'b0;
            end else begin
               drive_heading();
               ticks_left = high_ticks;
               in_high    = 1'b1;
            end
         end
      end
   endtask

   function automatic logic [7:0] leg_duty_for(input logic [DATA_W-1:0] data);
      int v;
      v = int'(data) * int'(gain_cfg) + int'(offset_cfg);
      if (data == '0) return 8'd0;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // Apply one accepted item to the predicted state, and return the outputs.
   task automatic step_controller(input logic [MODE_W-1:0] mode,
                                  input logic [BYTE_W-1:0] cmd,
                                  input logic [SIDX_W-1:0] idx,
                                  input logic [BYTE_W-1:0] val,
                                  output outputs_type o);
      logic [CODE_W-1:0] code;
      logic [DATA_W-1:0] data;
      logic [1:0] leg;
      bit loaded;
      code = cmd[7:5];
      data = cmd[4:0];
      loaded = 1'b0;
      if (mode == MODE_COMMAND) begin
         case (code)
            CODE_SENSOR: begin
               if (data >= 5'd1 && data <= DATA_W'(SENSOR_COUNT)) begin
                  reply_q = sensor_mem[SIDX_W'(data - 5'd1)];
                  loaded  = 1'b1;
               end else if (data == DATA_LED_ON) begin
                  led_q = 1'b0;
               end else if (data == DATA_LED_OFF) begin
                  led_q = 1'b1;
               end else if (data == DATA_LED_TOGGLE) begin
                  led_q = !led_q;
               end
            end
            CODE_RESET: begin
               // This leaves a running turret PWM untouched.
               if (data == DATA_ALL_RESET) begin
                  for (int i = 0; i < LEG_COUNT; i++) leg_duty[i] = 8'd0;
                  drive_left  = 1'b0;
                  drive_right = 1'b0;
                  led_q       = 1'b1;
               end
            end
            CODE_RIGHT: begin
               heading_left = 1'b0;
               turret_duty(data);
            end
            CODE_LEFT: begin
               heading_left = 1'b1;
               turret_duty(data);
            end
            default: begin
               // The opposite leg of the same motor is always cleared.
               leg = 2'(code - CODE_M1_FWD);
               leg_duty[leg ^ 2'd1] = 8'd0;
               leg_duty[leg]        = leg_duty_for(data);
            end
         endcase
      end else if (mode == MODE_TICK) begin
         pwm_tick();
      end else if (mode == MODE_SAMPLE) begin
         if ({1'b0, idx} < (SIDX_W + 1)'(SENSOR_COUNT)) sensor_mem[idx] = val;
      end
      o.m1_fwd      = leg_duty[0];
      o.m1_rev      = leg_duty[1];
      o.m2_fwd      = leg_duty[2];
      o.m2_rev      = leg_duty[3];
      o.left_drive  = drive_left;
      o.right_drive = drive_right;
      o.led         = led_q;
      o.reply       = reply_q;
      o.loaded      = loaded;
   endtask

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // Both handshakes are observed at the rising edge, before the controller's
   // registers update. A result leaves only after its item has passed the input
   // and result registers, so the pop always refers to an older item than the push.
   always @(posedge clock) begin
      outputs_type want;
      outputs_type got;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.m1_fwd      = rsp_chan.motor1_forward_duty;
            got.m1_rev      = rsp_chan.motor1_reverse_duty;
            got.m2_fwd      = rsp_chan.motor2_forward_duty;
            got.m2_rev      = rsp_chan.motor2_reverse_duty;
            got.left_drive  = rsp_chan.turret_left_drive;
            got.right_drive = rsp_chan.turret_right_drive;
            got.led         = rsp_chan.led_level;
            got.reply       = rsp_chan.reply_byte;
            got.loaded      = rsp_chan.reply_loaded;
            if (expected_outputs.size() == 0) begin
               $display("%0t ns: result item with nothing expected, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_outputs.pop_front();
               check_field("motor1_forward_duty", int'(want.m1_fwd), int'(got.m1_fwd));
               check_field("motor1_reverse_duty", int'(want.m1_rev), int'(got.m1_rev));
               check_field("motor2_forward_duty", int'(want.m2_fwd), int'(got.m2_fwd));
               check_field("motor2_reverse_duty", int'(want.m2_rev), int'(got.m2_rev));
               check_field("turret_left_drive", int'(want.left_drive),
                           int'(got.left_drive));
               check_field("turret_right_drive", int'(want.right_drive),
                           int'(got.right_drive));
               check_field("led_level", int'(want.led), int'(got.led));
               check_field("reply_byte", int'(want.reply), int'(got.reply));
               check_field("reply_loaded", int'(want.loaded), int'(got.loaded));
            end
            rsp_wait = no_idle ? 0 : int'($urandom_range(0, 3));
         end
         if (req_chan.valid && req_chan.ready) begin
            step_controller(req_chan.mode, req_chan.command_byte, req_chan.sensor_index,
                            req_chan.sensor_value, want);
            expected_outputs.push_back(want);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Clock, receiver and time limit
   // -------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver holds ready low for the stall that was drawn when the
   // previous result item was taken, then raises it until the next one.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // A correct run needs well under a tenth of this time.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus primitives. Each starts and ends just after a falling edge.
   // -------------------------------------------------------------------------

   // Offer one item after a random gap and hold it until it is accepted. With
   // no gap, valid simply stays high into the next item.
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] cmd,
                            input logic [SIDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      int gap;
      gap = no_idle ? 0 : int'($urandom_range(0, 3));
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.mode         <= mode;
      req_chan.command_byte <= cmd;
      req_chan.sensor_index <= idx;
      req_chan.sensor_value <= val;
      req_chan.valid        <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // The fields that a command ignores carry random noise.
   task automatic send_command(input code_type code, input logic [DATA_W-1:0] data);
      send_item(MODE_COMMAND, {code, data}, SIDX_W'($urandom_range(0, 7)),
                BYTE_W'($urandom));
   endtask

   task automatic send_tick();
      send_item(MODE_TICK, BYTE_W'($urandom), SIDX_W'($urandom_range(0, 7)),
                BYTE_W'($urandom));
   endtask

   task automatic send_sample(input logic [SIDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      send_item(MODE_SAMPLE, BYTE_W'($urandom), idx, val);
   endtask

   // Stop offering items and wait until every owed result has been taken.
   // The extra wait at the end covers the result register emptying.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (expected_outputs.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_MOTOR_GAIN:   gain_cfg   = value[7:0];
         CSR_MOTOR_OFFSET: offset_cfg = value[7:0];
         CSR_PWM_PERIOD:   period_cfg = value;
         CSR_DUTY_STEP:    step_cfg   = value;
         CSR_DUTY_OFFSET:  base_cfg   = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Registers are only written with the controller idle. Back-to-back writes
   // keep the enable high, and it is lowered once after the last one.
   task automatic configure(input logic [7:0] gain, input logic [7:0] offset,
                            input logic [15:0] period, input logic [15:0] step,
                            input logic [15:0] base);
      settle();
      write_reg(CSR_MOTOR_GAIN, CSR_W'(gain));
      write_reg(CSR_MOTOR_OFFSET, CSR_W'(offset));
      write_reg(CSR_PWM_PERIOD, period);
      write_reg(CSR_DUTY_STEP, step);
      write_reg(CSR_DUTY_OFFSET, base);
      csr_we <= 1'b0;
   endtask

   // Data values are biased toward the ones that each code acts on.
   task automatic send_random_command();
      code_type code;
      logic [DATA_W-1:0] data;
      int pick;
      code = code_type'($urandom_range(0, 7));
      data = DATA_W'($urandom);
      pick = $urandom_range(0, 99);
      case (code)
         CODE_SENSOR: begin
            if (pick < 55) data = DATA_W'($urandom_range(1, SENSOR_COUNT));
            else if (pick < 85) data = DATA_W'($urandom_range(DATA_LED_ON, DATA_LED_TOGGLE));
         end
         CODE_RESET: begin
            if (pick < 30) data = DATA_ALL_RESET;
         end
         CODE_RIGHT, CODE_LEFT: begin
            if (pick < 10) data = '0;
            else if (pick < 20) data = DATA_W'(MAX_DUTY);
         end
         default: begin
            if (pick < 10) data = '0;
         end
      endcase
      send_command(code, data);
   endtask

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) send_tick();
      else if (pick < 85) send_random_command();
      else if (pick < 96) send_sample(SIDX_W'($urandom_range(0, 7)), BYTE_W'($urandom));
      else send_item(MODE_UNUSED, BYTE_W'($urandom), SIDX_W'($urandom_range(0, 7)),
                     BYTE_W'($urandom));
   endtask

   // A turret command with a running duty followed by a run of ticks, with
   // the odd unrelated item mixed in. This is what exercises the soft PWM.
   task automatic pwm_burst();
      int run_length;
      run_length = $urandom_range(10, 60);
      send_command($urandom_range(0, 1) ? CODE_LEFT : CODE_RIGHT,
                   DATA_W'($urandom_range(1, MAX_DUTY - 1)));
      repeat (run_length) begin
         if ($urandom_range(0, 9) == 0) send_random_item();
         else send_tick();
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset configuration: sensor store and readback, rejected indexes and
   // command data, the LED commands, the motor legs up to a full duty of 255,
   // the turret stop and hold cases, the output reset and the unused mode.
   task automatic test_directed_commands();
      send_sample(3'd0, 8'hFF);
      send_sample(3'd4, 8'hA5);
      send_sample(3'd1, 8'h00);
      send_sample(3'd7, 8'h3C);
      send_sample(3'd5, 8'hFF);
      send_command(CODE_SENSOR, 5'd1);
      send_command(CODE_SENSOR, 5'd5);
      send_command(CODE_SENSOR, 5'd2);
      send_command(CODE_SENSOR, 5'd0);
      send_command(CODE_SENSOR, 5'd6);
      send_command(CODE_SENSOR, DATA_LED_ON);
      send_command(CODE_SENSOR, DATA_LED_TOGGLE);
      send_command(CODE_SENSOR, DATA_LED_TOGGLE);
      send_command(CODE_SENSOR, DATA_LED_OFF);
      send_command(CODE_M1_FWD, 5'd31);
      send_command(CODE_M1_REV, 5'd1);
      send_command(CODE_M2_FWD, 5'd0);
      send_command(CODE_M2_REV, 5'd20);
      send_tick();
      send_command(CODE_LEFT, DATA_W'(MAX_DUTY));
      send_command(CODE_RIGHT, 5'd0);
      send_command(CODE_RIGHT, 5'd1);
      send_tick();
      send_command(CODE_RESET, 5'd30);
      send_command(CODE_RESET, DATA_ALL_RESET);
      send_item(MODE_UNUSED, 8'hFF, 3'd7, 8'hFF);
      send_item(MODE_COMMAND, 8'hFF, 3'd7, 8'hFF);
      send_command(CODE_RIGHT, 5'd0);
   endtask

   // A short period makes the turret toggle every few ticks. This covers
   // heading changes while running, the output reset during a run, the
   // hold-high stop and a stretch with no idling on either side.
   task automatic test_turret_pwm();
      configure(RESET_MOTOR_GAIN, RESET_MOTOR_OFFSET, 16'd24, 16'd1, 16'd3);
      send_command(CODE_LEFT, 5'd5);
      repeat (40) send_tick();
      send_command(CODE_RIGHT, 5'd12);
      repeat (40) send_tick();
      send_command(CODE_RESET, DATA_ALL_RESET);
      repeat (30) send_tick();
      no_idle = 1;
      send_command(CODE_LEFT, 5'd20);
      repeat (30) send_tick();
      no_idle = 0;
      send_command(CODE_LEFT, DATA_W'(MAX_DUTY));
      repeat (5) send_tick();
      send_command(CODE_RIGHT, 5'd3);
      repeat (30) send_tick();
      send_command(CODE_RIGHT, 5'd0);
      repeat (5) send_tick();
      repeat (4) pwm_burst();
   endtask

   // Each register at its maximum and minimum, the period at one. With all
   // maximums the high time wraps; a period below the high time wraps the low
   // time. A zero base and step give a zero high length spanning the full count.
   task automatic test_config_extremes();
      configure(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_command(CODE_M1_FWD, 5'd1);
      send_command(CODE_M2_REV, 5'd0);
      send_command(CODE_M1_REV, 5'd31);
      send_command(CODE_LEFT, 5'd1);
      repeat (4) send_tick();
      send_command(CODE_LEFT, 5'd0);

      configure(8'd0, 8'd0, 16'd1, 16'd2, 16'd5);
      send_command(CODE_M2_FWD, 5'd31);
      send_command(CODE_M1_FWD, 5'd7);
      send_command(CODE_RIGHT, 5'd3);
      repeat (5) send_tick();
      send_command(CODE_RIGHT, 5'd0);

      configure(8'd1, 8'd0, 16'd1, 16'd0, 16'd0);
      send_command(CODE_M2_REV, 5'd9);
      send_command(CODE_RIGHT, 5'd7);
      repeat (4) send_tick();
      send_command(CODE_LEFT, 5'd0);
   endtask

   // Random traffic in several configuration phases. Most of it is turret
   // bursts and random single items, one phase runs without idling, and each
   // phase pauses once until the controller has drained.
   task automatic test_random_traffic();
      int stop_at;
      int pause_at;
      bit paused;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) begin
            configure(RESET_MOTOR_GAIN, RESET_MOTOR_OFFSET, RESET_PWM_PERIOD,
                      RESET_DUTY_STEP, RESET_DUTY_OFFSET);
         end else begin
            configure(8'($urandom), 8'($urandom), 16'($urandom_range(20, 150)),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 20)));
         end
         no_idle  = (phase == 3);
         stop_at  = items_sent + 215;
         pause_at = items_sent + 100;
         paused   = 1'b0;
         while (items_sent < stop_at) begin
            if (!paused && items_sent >= pause_at) begin
               settle();
               paused = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) pwm_burst();
            else send_random_item();
         end
         no_idle = 0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.mode         = MODE_COMMAND;
      req_chan.command_byte = '0;
      req_chan.sensor_index = '0;
      req_chan.sensor_value = '0;
      csr_we                = 1'b0;
      csr_index             = CSR_MOTOR_GAIN;
      csr_data              = '0;

      // Predicted state after reset: LED dark, heading left, PWM stopped.
      gain_cfg     = RESET_MOTOR_GAIN;
      offset_cfg   = RESET_MOTOR_OFFSET;
      period_cfg   = RESET_PWM_PERIOD;
      step_cfg     = RESET_DUTY_STEP;
      base_cfg     = RESET_DUTY_OFFSET;
      for (int i = 0; i < SENSOR_COUNT; i++) sensor_mem[i] = 8'd0;
      for (int i = 0; i < LEG_COUNT; i++) leg_duty[i] = 8'd0;
      drive_left   = 1'b0;
      drive_right  = 1'b0;
      heading_left = 1'b1;
      in_high      = 1'b0;
      pwm_on       = 1'b0;
      high_ticks   = 16'd0;
      low_ticks    = 16'd0;
      ticks_left   = 16'd0;
      led_q        = 1'b1;
      reply_q      = 8'd0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_commands();
      test_turret_pwm();
      test_config_extremes();
      test_random_traffic();

      // Drain the last results, then allow the pipeline latency to pass.
      settle();
      if (errors == 0 && expected_outputs.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
